// ===== design/csa_pkg.sv =====
// csa_pkg: shared constants and types of the chunk slot allocator
// used by csa_cell and chunk_slot_allocator_core; no dependencies
`timescale 1ns / 1ps

package csa_pkg;

	// default configuration of the top level
	localparam int DEF_CLASS_COUNT = 4;
	localparam int DEF_SLOT_BITS   = 20;
	localparam int DEF_STACK_DEPTH = 1024;

	// fixed field widths
	localparam int HANDLE_W = 28;
	localparam int COUNT_W  = 21;
	localparam int SIZE_W   = 32;
	localparam int WIDE_W   = 53;
	localparam int FREED_W  = 11;
	localparam int STATUS_W = 3;
	localparam int FUNC_W   = 2;
	localparam int CLSEL_W  = 2;

	// number of search cells in the chain (power of two)
	localparam int CELL_BITS  = 4;
	localparam int CELL_COUNT = 1 << CELL_BITS;

	// valid entry count of one stack row
	typedef logic [CELL_BITS:0] csa_fill_t;

	// control handed from the sequencer to every cell
	typedef struct packed {
		logic                 search;
		csa_fill_t            fill;
		logic                 wr_en;
		logic [CELL_BITS-1:0] wr_cell;
	} csa_cell_ctl_t;

endpackage

// ===== design/chunk_slot_allocator_core.sv =====
// chunk_slot_allocator_core: top level of the chunk slot allocator
// depends on csa_pkg, csa_cell and csa_ram
`timescale 1ns / 1ps

// Allocates, releases and looks up chunk slots for CLASS_COUNT size classes.
// Each class has a high-water counter and a LIFO stack of released slots; the
// stacks live in a chain of 16 cells, each cell one column of every stack in
// its own RAM, so a stack row of 16 entries is checked per cycle and the hit
// flags travel down the chain. One request is in work at a time, and a result
// waiting on the output does not hold off the next request. Release and
// lookup scan the class stack row by row through the cell RAMs and then
// drain the hit chain. Size registers may be written only while idle.
// There is no clearing pass after reset.
module chunk_slot_allocator_core
	import csa_pkg::*;
#(
	parameter int CLASS_COUNT = DEF_CLASS_COUNT,
	parameter int SLOT_BITS   = DEF_SLOT_BITS,
	parameter int STACK_DEPTH = DEF_STACK_DEPTH
) (
	input  logic         clk,
	input  logic         arst_n,
	// request words
	input  logic         s_axis_tvalid,
	output logic         s_axis_tready,
	// func[1:0], size_class[3:2], handle_in[31:4]
	input  logic [31:0]  s_axis_tdata,
	// result words
	output logic         m_axis_tvalid,
	input  logic         m_axis_tready,
	// status[2:0], handle_out[30:3], byte_offset[83:31], chunk_bytes[115:84],
	// grow_to_bytes[168:116], allocated_count[189:169], freed_count[200:190]
	output logic [207:0] m_axis_tdata,
	// configuration
	input  logic         cfg_we,
	input  logic [1:0]   cfg_index,
	input  logic [31:0]  cfg_data
);

	localparam int CW        = (CLASS_COUNT > 1) ? $clog2(CLASS_COUNT) : 1;
	localparam int DW        = $clog2(STACK_DEPTH + 1);
	localparam int SW        = (SLOT_BITS < COUNT_W) ? SLOT_BITS : COUNT_W;
	localparam int ROWS      = (STACK_DEPTH + CELL_COUNT - 1) / CELL_COUNT;
	localparam int RAM_DEPTH = CLASS_COUNT * ROWS;
	localparam int AW        = (RAM_DEPTH > 1) ? $clog2(RAM_DEPTH) : 1;
	localparam int RW        = (ROWS > 1) ? $clog2(ROWS) : 1;
	localparam int HSB       = (SLOT_BITS < HANDLE_W) ? SLOT_BITS : HANDLE_W;
	localparam logic [HANDLE_W-1:0] HSLOT_MASK = {HANDLE_W{1'b1}} >> (HANDLE_W - HSB);
	localparam int DRW       = $clog2(CELL_COUNT + 3);
	localparam logic [COUNT_W-1:0] COUNT_MAX = {COUNT_W{1'b1}};

	// request functions
	localparam logic [FUNC_W-1:0] FN_ALLOC   = 2'd0;
	localparam logic [FUNC_W-1:0] FN_RELEASE = 2'd1;

	// status codes
	localparam logic [STATUS_W-1:0] STS_OK        = 3'd0;
	localparam logic [STATUS_W-1:0] STS_BAD_CLASS = 3'd1;
	localparam logic [STATUS_W-1:0] STS_BEYOND    = 3'd2;
	localparam logic [STATUS_W-1:0] STS_FREED     = 3'd3;
	localparam logic [STATUS_W-1:0] STS_CAPACITY  = 3'd4;
	localparam logic [STATUS_W-1:0] STS_FULL      = 3'd5;

	// size register reset values
	localparam logic [SIZE_W-1:0] SIZE0_RST = 32'd4096;
	localparam logic [SIZE_W-1:0] SIZE1_RST = 32'd16384;
	localparam logic [SIZE_W-1:0] SIZE2_RST = 32'd65536;
	localparam logic [SIZE_W-1:0] SIZE3_RST = 32'd262144;

	// sequencer states
	localparam logic [3:0] ST_IDLE     = 4'd0;
	localparam logic [3:0] ST_DEC      = 4'd1;
	localparam logic [3:0] ST_POP      = 4'd2;
	localparam logic [3:0] ST_SCAN     = 4'd3;
	localparam logic [3:0] ST_DRAIN    = 4'd4;
	localparam logic [3:0] ST_CHK      = 4'd5;
	localparam logic [3:0] ST_MUL_OFS  = 4'd6;
	localparam logic [3:0] ST_MUL_GROW = 4'd7;
	localparam logic [3:0] ST_DONE     = 4'd8;

	logic [3:0]           state_q;
	logic [FUNC_W-1:0]    func_q;
	logic [CLSEL_W-1:0]   sclass_q;
	logic [HANDLE_W-1:0]  handle_q;
	logic [CW-1:0]        cls_q;
	logic                 cls_ok_q;
	logic [COUNT_W-1:0]   slot_q;
	logic [STATUS_W-1:0]  status_q;
	logic [HANDLE_W-1:0]  hout_q;
	logic                 fresh_q;
	logic                 found_q;
	logic [RW-1:0]        row_q;
	logic [DRW-1:0]       drain_q;
	logic [WIDE_W-1:0]    offset_q;
	logic [WIDE_W-1:0]    grow_q;
	logic [COUNT_W-1:0]   hw_q   [CLASS_COUNT];
	logic [DW-1:0]        dep_q  [CLASS_COUNT];
	logic [SIZE_W-1:0]    size_q [4];
	logic                 out_valid_q;
	logic [207:0]         out_data_q;

	// decode of the held request
	logic                 is_alloc;
	logic [HANDLE_W-1:0]  hidx;
	logic [HANDLE_W-1:0]  hslot;
	logic                 cls_ok_d;
	logic [CW-1:0]        cls_d;
	logic [COUNT_W-1:0]   hw_d;
	logic [DW-1:0]        dep_d;
	logic                 cap_hit;
	logic [HANDLE_W-1:0]  fresh_handle;

	// per class values of the current request
	logic [DW-1:0]        dep_c;
	logic [SIZE_W-1:0]    size_c;
	logic                 scan_last;
	logic [31:0]          row_rem;
	logic                 push;

	// stack ram ports
	logic [CW-1:0]        rd_cls;
	logic [RW-1:0]        rd_row;
	logic [AW-1:0]        rd_addr;
	logic [AW-1:0]        wr_addr;
	logic [CELL_BITS-1:0] pop_cell;
	csa_cell_ctl_t        cell_ctl;
	logic [SW-1:0]        cell_rdata [CELL_COUNT];
	logic [CELL_COUNT:0]  link_w;
	logic [SW-1:0]        pop_entry;

	// shared multiplier
	logic [COUNT_W:0]     mul_a;
	logic [COUNT_W+SIZE_W:0] prod;

	assign s_axis_tready = (state_q == ST_IDLE);

	// request decode
	assign is_alloc = (func_q == FN_ALLOC);
	assign hidx     = handle_q >> SLOT_BITS;
	assign hslot    = handle_q & HSLOT_MASK;
	assign cls_ok_d = is_alloc ? (32'(sclass_q) < CLASS_COUNT) : (32'(hidx) < CLASS_COUNT);
	assign cls_d    = is_alloc ? CW'(sclass_q) : CW'(hidx);
	assign hw_d     = hw_q[cls_d];
	assign dep_d    = dep_q[cls_d];
	assign cap_hit  = ((64'(hw_d) >> SLOT_BITS) != 64'd0) || (hw_d >= COUNT_MAX);
	assign fresh_handle = HANDLE_W'((64'(cls_d) << SLOT_BITS) | 64'(hw_d));

	assign dep_c  = dep_q[cls_q];
	assign size_c = size_q[CLSEL_W'(cls_q)];

	// scan bookkeeping
	assign scan_last = ((32'(row_q) + 32'd1) << CELL_BITS) >= 32'(dep_c);
	assign row_rem   = 32'(dep_c) - (32'(row_q) << CELL_BITS);
	assign push      = (state_q == ST_CHK) && !found_q && (func_q == FN_RELEASE)
		&& (32'(dep_c) < STACK_DEPTH);

	// read address: top entry while decoding, scan row otherwise
	always_comb begin
		if (state_q == ST_DEC) begin
			rd_cls = cls_d;
			rd_row = RW'((32'(dep_d) - 32'd1) >> CELL_BITS);
		end else begin
			rd_cls = cls_q;
			rd_row = row_q;
		end
	end

	assign rd_addr  = AW'(32'(rd_cls) * ROWS + 32'(rd_row));
	assign wr_addr  = AW'(32'(cls_q) * ROWS + (32'(dep_c) >> CELL_BITS));
	assign pop_cell = CELL_BITS'(32'(dep_c) - 32'd1);

	// control word for the cell chain
	always_comb begin
		cell_ctl.search  = (state_q == ST_SCAN);
		cell_ctl.fill    = (row_rem >= CELL_COUNT) ? csa_fill_t'(CELL_COUNT)
			: csa_fill_t'(row_rem);
		cell_ctl.wr_en   = push;
		cell_ctl.wr_cell = CELL_BITS'(dep_c);
	end

	// chain of search cells
	assign link_w[0] = 1'b0;

	for (genvar g = 0; g < CELL_COUNT; g++) begin : g_cell
		csa_cell #(
			.SW        (SW),
			.RAM_DEPTH (RAM_DEPTH),
			.INDEX     (g)
		) u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.ctl      (cell_ctl),
			.rd_addr  (rd_addr),
			.wr_addr  (wr_addr),
			.wr_data  (SW'(slot_q)),
			.key      (SW'(slot_q)),
			.link_in  (link_w[g]),
			.link_out (link_w[g+1]),
			.rd_data  (cell_rdata[g])
		);
	end

	assign pop_entry = cell_rdata[pop_cell];

	// one multiplier, slot or slot plus one times chunk size
	assign mul_a = (state_q == ST_MUL_GROW) ? ((COUNT_W+1)'(slot_q) + 1'b1)
		: (COUNT_W+1)'(slot_q);
	assign prod  = mul_a * size_c;

	// size registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			size_q[0] <= SIZE0_RST;
			size_q[1] <= SIZE1_RST;
			size_q[2] <= SIZE2_RST;
			size_q[3] <= SIZE3_RST;
		end else if (cfg_we) begin
			size_q[cfg_index] <= cfg_data;
		end
	end

	// per class counters
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < CLASS_COUNT; i++) begin
				hw_q[i]  <= '0;
				dep_q[i] <= '0;
			end
		end else begin
			if (state_q == ST_DEC && cls_ok_d && is_alloc && dep_d == '0 && !cap_hit) begin
				hw_q[cls_d] <= hw_d + 1'b1;
			end
			if (state_q == ST_POP) begin
				dep_q[cls_q] <= dep_c - 1'b1;
			end else if (push) begin
				dep_q[cls_q] <= dep_c + 1'b1;
			end
		end
	end

	// sticky hit collector at the end of the chain
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			found_q <= 1'b0;
		end else if (state_q == ST_DEC) begin
			found_q <= 1'b0;
		end else begin
			found_q <= found_q | link_w[CELL_COUNT];
		end
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			if (out_valid_q && m_axis_tready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (s_axis_tvalid) begin
						state_q <= ST_DEC;
					end
				end
				ST_DEC: begin
					if (!cls_ok_d) begin
						state_q <= ST_DONE;
					end else if (is_alloc) begin
						if (dep_d != '0) begin
							state_q <= ST_POP;
						end else if (cap_hit) begin
							state_q <= ST_DONE;
						end else begin
							state_q <= ST_MUL_OFS;
						end
					end else if (32'(hslot) >= 32'(hw_d)) begin
						state_q <= ST_DONE;
					end else if (dep_d == '0) begin
						state_q <= ST_CHK;
					end else begin
						state_q <= ST_SCAN;
					end
				end
				ST_POP: begin
					state_q <= ST_MUL_OFS;
				end
				ST_SCAN: begin
					if (scan_last) begin
						state_q <= ST_DRAIN;
					end
				end
				ST_DRAIN: begin
					if (drain_q == DRW'(CELL_COUNT + 1)) begin
						state_q <= ST_CHK;
					end
				end
				ST_CHK: begin
					if (found_q) begin
						state_q <= ST_DONE;
					end else if (func_q == FN_RELEASE && 32'(dep_c) >= STACK_DEPTH) begin
						state_q <= ST_DONE;
					end else begin
						state_q <= ST_MUL_OFS;
					end
				end
				ST_MUL_OFS: begin
					state_q <= fresh_q ? ST_MUL_GROW : ST_DONE;
				end
				ST_MUL_GROW: begin
					state_q <= ST_DONE;
				end
				ST_DONE: begin
					if (!out_valid_q || m_axis_tready) begin
						out_valid_q <= 1'b1;
						state_q     <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// request and working registers
	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				func_q   <= s_axis_tdata[1:0];
				sclass_q <= s_axis_tdata[3:2];
				handle_q <= s_axis_tdata[31:4];
			end
			ST_DEC: begin
				cls_q    <= cls_d;
				cls_ok_q <= cls_ok_d;
				status_q <= STS_OK;
				hout_q   <= is_alloc ? '0 : handle_q;
				offset_q <= '0;
				grow_q   <= '0;
				fresh_q  <= 1'b0;
				row_q    <= '0;
				drain_q  <= '0;
				slot_q   <= COUNT_W'(hslot);
				if (!cls_ok_d) begin
					status_q <= STS_BAD_CLASS;
				end else if (is_alloc) begin
					if (dep_d == '0) begin
						if (cap_hit) begin
							status_q <= STS_CAPACITY;
						end else begin
							slot_q  <= hw_d;
							fresh_q <= 1'b1;
							hout_q  <= fresh_handle;
						end
					end
				end else if (32'(hslot) >= 32'(hw_d)) begin
					status_q <= STS_BEYOND;
				end
			end
			ST_POP: begin
				slot_q <= COUNT_W'(pop_entry);
				hout_q <= HANDLE_W'((64'(cls_q) << SLOT_BITS) | 64'(pop_entry));
			end
			ST_SCAN: begin
				row_q <= row_q + 1'b1;
			end
			ST_DRAIN: begin
				drain_q <= drain_q + 1'b1;
			end
			ST_CHK: begin
				if (found_q) begin
					status_q <= STS_FREED;
				end else if (func_q == FN_RELEASE && 32'(dep_c) >= STACK_DEPTH) begin
					status_q <= STS_FULL;
				end
			end
			ST_MUL_OFS: begin
				offset_q <= prod[WIDE_W-1:0];
			end
			ST_MUL_GROW: begin
				grow_q <= prod[WIDE_W-1:0];
			end
			default: begin
			end
		endcase
	end

	// output register
	always_ff @(posedge clk) begin
		if (state_q == ST_DONE && (!out_valid_q || m_axis_tready)) begin
			out_data_q <= {
				7'd0,
				cls_ok_q ? FREED_W'(dep_c) : FREED_W'(0),
				cls_ok_q ? hw_q[cls_q] : COUNT_W'(0),
				grow_q,
				cls_ok_q ? size_c : SIZE_W'(0),
				offset_q,
				hout_q,
				status_q
			};
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = out_data_q;

endmodule

// ===== design/csa_ram.sv =====
// csa_ram: generic single write port, single read port ram with registered read
// no dependencies
`timescale 1ns / 1ps

module csa_ram #(
	parameter int W     = 8,
	parameter int DEPTH = 16
) (
	input  logic                                        clk,
	input  logic                                        we,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [W-1:0]                                wdata,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [W-1:0]                                rdata
);

	logic [W-1:0] mem_q [DEPTH];

	// write port and registered read port
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

// ===== design/csa_cell.sv =====
// csa_cell: one cell of the free stack chain; holds one column of every class
// stack in a csa_ram, compares its entry with the key and passes a hit flag on
// depends on csa_pkg and csa_ram
`timescale 1ns / 1ps

module csa_cell
	import csa_pkg::*;
#(
	parameter int SW        = 20,
	parameter int RAM_DEPTH = 256,
	parameter int INDEX     = 0
) (
	input  logic                                                clk,
	input  logic                                                arst_n,
	input  csa_cell_ctl_t                                       ctl,
	input  logic [((RAM_DEPTH > 1) ? $clog2(RAM_DEPTH) : 1)-1:0] rd_addr,
	input  logic [((RAM_DEPTH > 1) ? $clog2(RAM_DEPTH) : 1)-1:0] wr_addr,
	input  logic [SW-1:0]                                       wr_data,
	input  logic [SW-1:0]                                       key,
	input  logic                                                link_in,
	output logic                                                link_out,
	output logic [SW-1:0]                                       rd_data
);

	logic      search_s1;
	csa_fill_t fill_s1;
	logic      we;
	logic      hit;
	logic      link_q;

	// this cell's column of the stacks
	assign we = ctl.wr_en && (ctl.wr_cell == CELL_BITS'(INDEX));

	csa_ram #(
		.W     (SW),
		.DEPTH (RAM_DEPTH)
	) u_ram (
		.clk   (clk),
		.we    (we),
		.waddr (wr_addr),
		.wdata (wr_data),
		.raddr (rd_addr),
		.rdata (rd_data)
	);

	// search control is registered once to line up with the registered read data
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			search_s1 <= 1'b0;
			fill_s1   <= '0;
		end else begin
			search_s1 <= ctl.search;
			fill_s1   <= ctl.fill;
		end
	end

	// entry counts only when it lies below the fill of the stack row
	assign hit = search_s1 && (csa_fill_t'(INDEX) < fill_s1) && (rd_data == key);

	// hit flag moves one cell per cycle toward the end of the chain
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			link_q <= 1'b0;
		end else begin
			link_q <= link_in | hit;
		end
	end

	assign link_out = link_q;

endmodule
